/* sv/chd_pkg.sv */
// Shared types, constants and decode functions for the cartridge header decoder.
`timescale 1ns / 1ps
`default_nettype none

package chd_pkg;

  typedef enum logic [2:0] {
    STATUS_OK           = 3'd0,
    STATUS_BAD_MAGIC    = 3'd1,
    STATUS_CONSOLE_TYPE = 3'd2,
    STATUS_TIMING       = 3'd3,
    STATUS_EXPANSION    = 3'd4
  } chd_status_e;

  // Header byte positions that carry a check or a field
  localparam logic [3:0] POS_MAGIC_LAST = 4'd3;
  localparam logic [3:0] POS_PRG_LSB    = 4'd4;
  localparam logic [3:0] POS_CHR_LSB    = 4'd5;
  localparam logic [3:0] POS_FLAGS6     = 4'd6;
  localparam logic [3:0] POS_FLAGS7     = 4'd7;
  localparam logic [3:0] POS_MAPPER_HI  = 4'd8;
  localparam logic [3:0] POS_ROM_MSB    = 4'd9;
  localparam logic [3:0] POS_PRG_RAM    = 4'd10;
  localparam logic [3:0] POS_CHR_RAM    = 4'd11;
  localparam logic [3:0] POS_TIMING     = 4'd12;
  localparam logic [3:0] POS_MISC_ROM   = 4'd14;
  localparam logic [3:0] POS_LAST       = 4'd15;

  localparam logic [1:0] VERSION_2      = 2'b10;
  localparam logic [3:0] ROM_EXP_FORM   = 4'hF;
  localparam logic [3:0] PRG_UNIT_SHIFT = 4'd14;
  localparam logic [3:0] CHR_UNIT_SHIFT = 4'd13;
  localparam logic [21:0] OLD_RAM_BYTES = 22'h2000;
  localparam logic [21:0] RAM_BASE      = 22'd64;

  localparam int unsigned OUT_DATA_W = 248;

  function automatic logic [7:0] chd_magic(input logic [1:0] pos);
    logic [7:0] m;
    unique case (pos)
      2'd0:    m = 8'h4E;
      2'd1:    m = 8'h45;
      2'd2:    m = 8'h53;
      default: m = 8'h1A;
    endcase
    return m;
  endfunction

  // Size in bytes from a 12-bit count: unit count, or exponent-multiplier form
  function automatic logic [63:0] chd_rom_bytes(input logic [11:0] count,
                                                input logic [3:0]  unit_shift);
    logic [66:0] scaled;
    logic [63:0] bytes;
    scaled = 67'({count[1:0], 1'b1}) << count[7:2];
    if (count[11:8] == ROM_EXP_FORM) begin
      if (scaled[66:64] != 3'b000) begin
        bytes = '1;
      end else begin
        bytes = scaled[63:0];
      end
    end else begin
      bytes = 64'(count) << unit_shift;
    end
    return bytes;
  endfunction

  function automatic logic [21:0] chd_ram_bytes(input logic [3:0] shift);
    logic [21:0] bytes;
    if (shift == 4'd0) begin
      bytes = '0;
    end else begin
      bytes = RAM_BASE << shift;
    end
    return bytes;
  endfunction

endpackage

`default_nettype wire

/* sv/cartridge_header_decoder.sv */
// Top level: streaming decoder of the 16-byte cartridge header.
//
//  Channel   Dir  Transfer when             Payload
//  s_axis    in   tvalid & tready           tdata: header byte; tuser: first-byte flag
//  m_axis    out  tvalid & tready           tuser: status; tdata: decoded fields
//  apb       in   psel&penable&pwrite       force_load at any address with paddr[2] clear
//
// One header byte per cycle unless a result is blocked at the output; a byte passes
// an input register and the decode logic, and its result lands in the output
// register, from which it transfers on tvalid & tready. While a result waits,
// bytes keep flowing; only a byte that makes a result of its own stalls behind it.
// Reset clears the control state and leaves the decoder waiting for a byte
// flagged as first; bytes without that flag are dropped until then.
`timescale 1ns / 1ps
`default_nettype none

module cartridge_header_decoder (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // APB configuration
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  // header bytes in
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [7:0]   s_axis_tdata,  // [7:0] header_byte
  input  wire logic [0:0]   s_axis_tuser,  // [0] first_byte
  // result out
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // [11:0] mapper_number, [15:12] submapper, [79:16] prg_rom_bytes,
  // [143:80] chr_rom_bytes, [165:144] prg_ram_bytes, [187:166] prg_nvram_bytes,
  // [209:188] chr_ram_bytes, [231:210] chr_nvram_bytes, [232] extended_format,
  // [236:233] board_flags, [244:237] misc_rom_count, [247:245] zero
  output logic [chd_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic [2:0]        m_axis_tuser   // [2:0] status
);

  // configuration
  logic force_load_q;

  // input register
  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       in_first_q;

  // header tracking
  logic [3:0] pos_q, pos_d;
  logic       done_q, done_d;
  logic       mismatch_q, mismatch_d;

  // captured header bytes
  logic [7:0] prg_lsb_q, chr_lsb_q, flags6_q, flags7_q;
  logic [7:0] mapper_hi_q, rom_msb_q, prg_ram_q, chr_ram_q, misc_q;

  // output register
  logic                          out_valid_q, out_valid_d;
  chd_pkg::chd_status_e          out_status_q;
  logic [chd_pkg::OUT_DATA_W-1:0] out_data_q;

  // decode
  logic                 advance, work;
  logic [3:0]           eff_pos;
  logic                 eff_done, eff_mismatch, mismatch_now, is_v2;
  logic                 res_valid;
  chd_pkg::chd_status_e res_status;
  logic [chd_pkg::OUT_DATA_W-1:0] res_data;
  logic [11:0]          mapper, prg_count, chr_count;
  logic [63:0]          prg_rom, chr_rom;
  logic [21:0]          prg_ram, prg_nvram, chr_ram, chr_nvram;
  logic [3:0]           submapper;
  logic [7:0]           misc_count;

  // ---------------------------------------------------------------- APB
  assign pready = 1'b1;
  assign prdata = {31'b0, force_load_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      force_load_q <= 1'b0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
      force_load_q <= pwdata[0];
    end
  end

  // ---------------------------------------------------------------- flow
  // A byte leaves the input register unless it makes a result that cannot land
  assign advance       = !res_valid || !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;
  assign work          = in_valid_q && advance;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_axis_tready) begin
      in_valid_d = s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q  <= s_axis_tdata;
      in_first_q <= s_axis_tuser[0];
    end
  end

  // ---------------------------------------------------------------- decode
  assign eff_pos      = in_first_q ? 4'd0 : pos_q;
  assign eff_done     = in_first_q ? 1'b0 : done_q;
  assign eff_mismatch = in_first_q ? 1'b0 : mismatch_q;
  assign mismatch_now = eff_mismatch || (in_byte_q != chd_pkg::chd_magic(eff_pos[1:0]));
  assign is_v2        = (flags7_q[3:2] == chd_pkg::VERSION_2);

  // full-result fields, valid at the last byte
  always_comb begin
    mapper     = {4'h0, flags7_q[7:4], flags6_q[7:4]};
    prg_count  = {4'h0, prg_lsb_q};
    chr_count  = {4'h0, chr_lsb_q};
    submapper  = '0;
    misc_count = '0;
    prg_ram    = chd_pkg::OLD_RAM_BYTES;
    prg_nvram  = '0;
    chr_ram    = (chr_lsb_q == 8'h00) ? chd_pkg::OLD_RAM_BYTES : 22'd0;
    chr_nvram  = '0;
    if (is_v2) begin
      mapper[11:8] = mapper_hi_q[3:0];
      submapper    = mapper_hi_q[7:4];
      prg_count    = {rom_msb_q[3:0], prg_lsb_q};
      chr_count    = {rom_msb_q[7:4], chr_lsb_q};
      prg_ram      = chd_pkg::chd_ram_bytes(prg_ram_q[3:0]);
      prg_nvram    = chd_pkg::chd_ram_bytes(prg_ram_q[7:4]);
      chr_ram      = chd_pkg::chd_ram_bytes(chr_ram_q[3:0]);
      chr_nvram    = chd_pkg::chd_ram_bytes(chr_ram_q[7:4]);
      misc_count   = misc_q;
    end
    prg_rom = chd_pkg::chd_rom_bytes(prg_count, chd_pkg::PRG_UNIT_SHIFT);
    chr_rom = chd_pkg::chd_rom_bytes(chr_count, chd_pkg::CHR_UNIT_SHIFT);
  end

  // next header state and result
  always_comb begin
    pos_d      = pos_q;
    done_d     = done_q;
    mismatch_d = mismatch_q;
    res_valid  = 1'b0;
    res_status = chd_pkg::STATUS_OK;
    res_data   = '0;
    if (in_valid_q) begin
      pos_d      = eff_pos;
      done_d     = eff_done;
      mismatch_d = eff_mismatch;
      if (!eff_done) begin
        pos_d = eff_pos + 4'd1;
        if (eff_pos <= chd_pkg::POS_MAGIC_LAST) begin
          mismatch_d = mismatch_now;
          if (eff_pos == chd_pkg::POS_MAGIC_LAST && mismatch_now) begin
            res_valid  = 1'b1;
            res_status = chd_pkg::STATUS_BAD_MAGIC;
          end
        end else if (eff_pos == chd_pkg::POS_FLAGS7) begin
          if (in_byte_q[1:0] != 2'b00 && !force_load_q) begin
            res_valid  = 1'b1;
            res_status = chd_pkg::STATUS_CONSOLE_TYPE;
          end
        end else if (eff_pos == chd_pkg::POS_TIMING) begin
          if (is_v2 && in_byte_q[0]) begin
            res_valid  = 1'b1;
            res_status = chd_pkg::STATUS_TIMING;
          end
        end else if (eff_pos == chd_pkg::POS_LAST) begin
          res_valid = 1'b1;
          if (is_v2 && in_byte_q[5:0] > 6'd1) begin
            res_status = chd_pkg::STATUS_EXPANSION;
          end else begin
            res_data = {3'b000, misc_count, flags6_q[3:0], is_v2,
                        chr_nvram, chr_ram, prg_nvram, prg_ram,
                        chr_rom, prg_rom, submapper, mapper};
          end
        end
        if (res_valid) begin
          done_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      done_q     <= 1'b1;
      mismatch_q <= 1'b0;
    end else if (work) begin
      pos_q      <= pos_d;
      done_q     <= done_d;
      mismatch_q <= mismatch_d;
    end
  end

  // capture the bytes the result needs
  always_ff @(posedge clk_i) begin
    if (work && !eff_done) begin
      if (eff_pos == chd_pkg::POS_PRG_LSB)   prg_lsb_q   <= in_byte_q;
      if (eff_pos == chd_pkg::POS_CHR_LSB)   chr_lsb_q   <= in_byte_q;
      if (eff_pos == chd_pkg::POS_FLAGS6)    flags6_q    <= in_byte_q;
      if (eff_pos == chd_pkg::POS_FLAGS7)    flags7_q    <= in_byte_q;
      if (eff_pos == chd_pkg::POS_MAPPER_HI) mapper_hi_q <= in_byte_q;
      if (eff_pos == chd_pkg::POS_ROM_MSB)   rom_msb_q   <= in_byte_q;
      if (eff_pos == chd_pkg::POS_PRG_RAM)   prg_ram_q   <= in_byte_q;
      if (eff_pos == chd_pkg::POS_CHR_RAM)   chr_ram_q   <= in_byte_q;
      if (eff_pos == chd_pkg::POS_MISC_ROM)  misc_q      <= in_byte_q;
    end
  end

  // ---------------------------------------------------------------- output
  always_comb begin
    out_valid_d = out_valid_q;
    if (work && res_valid) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (work && res_valid) begin
      out_status_q <= res_status;
      out_data_q   <= res_data;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_status_q;

  // ---------------------------------------------------------------- checks
  a_error_zero_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (work && res_valid && res_status != chd_pkg::STATUS_OK) |-> (res_data == '0))
    else $error("error result carries nonzero fields");

  a_done_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (work && res_valid) |=> done_q)
    else $error("header not closed after its result");

  a_magic_at_byte3: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (work && res_valid && res_status == chd_pkg::STATUS_BAD_MAGIC)
      |-> (eff_pos == chd_pkg::POS_MAGIC_LAST))
    else $error("bad magic reported away from byte 3");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid_q && out_valid_q && res_valid && !m_axis_tready))
    else $error("input stalled without a blocked result");

endmodule

`default_nettype wire
